/* hw/rtl/pfgsp_pkg.sv */
// Shared types and constants for the PCM frame gain stereo packer.
package pfgsp_pkg;

	// Sample and byte widths of the PCM stream.
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned GAIN_W   = 16;

	// Q15 gain: the top gain bit set means unity or above.
	localparam int unsigned GAIN_SHIFT = 15;
	localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;

	// Configuration register map.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_Q15     = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MUTE_ENABLE  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_STEREO_INPUT = 2'd2;

	// Gain settings seen by the sample scaler.
	typedef struct packed {
		logic [GAIN_W-1:0] gain_q15;
		logic              mute_enable;
	} scale_cfg_t;

endpackage

/* hw/rtl/pfgsp_scale.sv */
// Q15 gain scaler for one 16-bit sample, with unity passthrough and mute.
module pfgsp_scale (
	input  pfgsp_pkg::scale_cfg_t           cfg,
	input  logic [pfgsp_pkg::SAMPLE_W-1:0]  raw,
	output logic signed [pfgsp_pkg::SAMPLE_W-1:0] scaled
);
	import pfgsp_pkg::*;

	logic signed [2*SAMPLE_W-1:0] prod;

	// Below unity the gain fits in 15 bits, so the product stays inside 31 bits.
	assign prod = $signed({{SAMPLE_W{raw[SAMPLE_W-1]}}, raw}) *
		$signed({{(SAMPLE_W+1){1'b0}}, cfg.gain_q15[GAIN_SHIFT-1:0]});

	// Mute wins, then unity passthrough, then the floor-shifted product.
	always_comb begin
		if (cfg.mute_enable) begin
			scaled = '0;
		end else if (cfg.gain_q15 >= UNITY_GAIN) begin
			scaled = $signed(raw);
		end else begin
			scaled = prod[GAIN_SHIFT+SAMPLE_W-1:GAIN_SHIFT];
		end
	end

endmodule

/* hw/rtl/pcm_frame_gain_stereo_packer.sv */
// Top level: gathers PCM bytes into frames and emits gain-scaled stereo samples.
//
//  Channel  Signals                                   Direction  Beat
//  in       in_valid, in_ready, data_byte             sink       one stream byte
//  out      out_valid, out_ready, left/right_sample   source     one stereo frame
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data sink       one register write
//
// One byte is taken per cycle while in_ready is high. After its last byte a frame
// is held in the frame register, then the gain multiply loads the output register.
// Reset clears the frame count and pipeline valids; ready rises the cycle after release.
// A stalled output holds its beat while the frame register keeps taking bytes
// until it is also full.
module pcm_frame_gain_stereo_packer (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [pfgsp_pkg::BYTE_W-1:0]            data_byte,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [pfgsp_pkg::SAMPLE_W-1:0]   left_sample,
	output logic signed [pfgsp_pkg::SAMPLE_W-1:0]   right_sample,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [pfgsp_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [pfgsp_pkg::GAIN_W-1:0]            cfg_data
);
	import pfgsp_pkg::*;

	logic                      run_q;
	logic [GAIN_W-1:0]         gain_q;
	logic                      mute_q;
	logic                      stereo_q;
	logic [1:0]                count_q;
	logic [BYTE_W-1:0]         byte0_q;
	logic [BYTE_W-1:0]         byte1_q;
	logic [BYTE_W-1:0]         byte2_q;
	logic                      vld_s1;
	logic [SAMPLE_W-1:0]       left_raw_s1;
	logic [SAMPLE_W-1:0]       right_raw_s1;
	logic                      vld_s2;
	logic signed [SAMPLE_W-1:0] left_s2;
	logic signed [SAMPLE_W-1:0] right_s2;
	logic                      load_s2;
	logic                      in_acc;
	logic                      frame_done;
	scale_cfg_t                scale_cfg;
	logic signed [SAMPLE_W-1:0] left_scaled;
	logic signed [SAMPLE_W-1:0] right_scaled;

	// Ready comes up in the cycle after reset is released.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	assign cfg_ready = run_q;

	// Configuration registers; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= UNITY_GAIN;
			mute_q   <= 1'b0;
			stereo_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GAIN_Q15:     gain_q   <= cfg_data;
				CFG_MUTE_ENABLE:  mute_q   <= cfg_data[0];
				CFG_STEREO_INPUT: stereo_q <= cfg_data[0];
				default:          ;
			endcase
		end
	end

	// Handshake: the output register loads when empty or drained.
	assign load_s2  = !vld_s2 || out_ready;
	assign in_ready = run_q && (!vld_s1 || load_s2);
	assign in_acc   = in_valid && in_ready;

	// A stereo frame ends on its fourth byte, a mono frame on any byte after the first.
	assign frame_done = stereo_q ? (count_q == 2'd3) : (count_q != 2'd0);

	// Byte gathering count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (in_acc) begin
			count_q <= frame_done ? 2'd0 : count_q + 2'd1;
		end
	end

	// Partial frame bytes, written at the current count.
	always_ff @(posedge clk) begin
		if (in_acc && !frame_done) begin
			case (count_q)
				2'd0:    byte0_q <= data_byte;
				2'd1:    byte1_q <= data_byte;
				2'd2:    byte2_q <= data_byte;
				default: ;
			endcase
		end
	end

	// Frame register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= frame_done;
		end else if (load_s2) begin
			vld_s1 <= 1'b0;
		end
	end

	// Frame register: raw little-endian samples; mono copies left to right.
	always_ff @(posedge clk) begin
		if (in_acc && frame_done) begin
			if (stereo_q) begin
				left_raw_s1  <= {byte1_q, byte0_q};
				right_raw_s1 <= {data_byte, byte2_q};
			end else begin
				left_raw_s1  <= {data_byte, byte0_q};
				right_raw_s1 <= {data_byte, byte0_q};
			end
		end
	end

	// Gain scaling of both channels.
	assign scale_cfg.gain_q15    = gain_q;
	assign scale_cfg.mute_enable = mute_q;

	pfgsp_scale u_scale_left (
		.cfg    (scale_cfg),
		.raw    (left_raw_s1),
		.scaled (left_scaled)
	);

	pfgsp_scale u_scale_right (
		.cfg    (scale_cfg),
		.raw    (right_raw_s1),
		.scaled (right_scaled)
	);

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (load_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_s2 && vld_s1) begin
			left_s2  <= left_scaled;
			right_s2 <= right_scaled;
		end
	end

	assign out_valid    = vld_s2;
	assign left_sample  = left_s2;
	assign right_sample = right_s2;

endmodule

/* hw/rtl/pfgsp_checker.sv */
// Port-level checker for the PCM frame gain stereo packer, bound to the top level.
module pfgsp_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [pfgsp_pkg::SAMPLE_W-1:0] left_sample,
	input logic signed [pfgsp_pkg::SAMPLE_W-1:0] right_sample,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready,
	input logic [pfgsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input logic [pfgsp_pkg::GAIN_W-1:0]          cfg_data
);
	import pfgsp_pkg::*;

	logic mute_q;
	logic stereo_q;

	// Shadow copies of the mode registers, tracked from the write beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q   <= 1'b0;
			stereo_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_MUTE_ENABLE) begin
				mute_q <= cfg_data[0];
			end
			if (cfg_index == CFG_STEREO_INPUT) begin
				stereo_q <= cfg_data[0];
			end
		end
	end

	// No output beat is offered while reset is asserted.
	assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// A stalled output beat holds its samples.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_sample) && $stable(right_sample))
		else $error("stalled output beat changed");

	// A new output beat must trace back to an accepted input beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output beat without matching input beat");

	// Muted output is all zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mute_q |-> left_sample == '0 && right_sample == '0)
		else $error("nonzero sample while muted");

	// Mono input yields identical channels.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !stereo_q |-> left_sample == right_sample)
		else $error("mono frame with differing channels");

endmodule

bind pcm_frame_gain_stereo_packer pfgsp_checker u_pfgsp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.left_sample  (left_sample),
	.right_sample (right_sample),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

/* tb/pcm_frame_gain_stereo_packer_tb.sv */
// Self-checking testbench for the PCM frame gain stereo packer.
`timescale 1ns / 100ps

module pcm_frame_gain_stereo_packer_tb;
	import pfgsp_pkg::*;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
	// Cycles without any beat on any channel before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 2000;
	// Cycles to wait after the last frame so bytes still in the pipeline settle.
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned BYTES_PER_PHASE = 450;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} stereo_frame_t;

	// Tracks the frame assembly and gain settings, and checks each output frame.
	class frame_scoreboard;
		logic [GAIN_W-1:0]     gain;
		bit                    mute;
		bit                    stereo;
		logic [BYTE_W-1:0]     held[3];
		int unsigned           held_cnt;
		stereo_frame_t         expected_frames[$];
		int unsigned           mismatches;

		function new();
			gain       = UNITY_GAIN;
			mute       = 1'b0;
			stereo     = 1'b1;
			held_cnt   = 0;
			mismatches = 0;
		endfunction

		// Mirror a register write; only the low bit of the flag registers counts.
		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [GAIN_W-1:0] data);
			case (idx)
				CFG_GAIN_Q15: begin
					gain = data;
				end
				CFG_MUTE_ENABLE: begin
					mute = data[0];
				end
				CFG_STEREO_INPUT: begin
					stereo = data[0];
				end
				default: begin
				end
			endcase
		endfunction

		// Q15 scaling with a floor shift; the top gain bit means unity.
		function logic signed [SAMPLE_W-1:0] apply_gain(logic [BYTE_W-1:0] lo,
			logic [BYTE_W-1:0] hi);
			logic signed [SAMPLE_W-1:0] raw;
			logic signed [32:0]         prod;
			raw = {hi, lo};
			if (mute)
				return '0;
			if (gain >= UNITY_GAIN)
				return raw;
			prod = 33'(raw) * 33'($signed({1'b0, gain}));
			return prod[GAIN_SHIFT +: SAMPLE_W];
		endfunction

		// Account for one accepted input beat and queue the frame it completes.
		function void take_byte(logic [BYTE_W-1:0] b);
			stereo_frame_t f;
			if (stereo) begin
				if (held_cnt < 3) begin
					held[held_cnt] = b;
					held_cnt++;
					return;
				end
				f.left  = apply_gain(held[0], held[1]);
				f.right = apply_gain(held[2], b);
			end else begin
				// A mono frame always pairs the first held byte with this one.
				if (held_cnt == 0) begin
					held[0]  = b;
					held_cnt = 1;
					return;
				end
				f.left  = apply_gain(held[0], b);
				f.right = f.left;
			end
			held_cnt = 0;
			expected_frames.push_back(f);
		endfunction

		// Compare one output beat against the oldest expected frame.
		function void check_frame(logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r);
			stereo_frame_t f;
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected frame: left %0d right %0d", l, r);
				return;
			end
			f = expected_frames.pop_front();
			if (l !== f.left || r !== f.right) begin
				mismatches++;
				if (mismatches <= 10)
					$display("frame mismatch: expected left %0d right %0d, got left %0d right %0d",
						f.left, f.right, l, r);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [BYTE_W-1:0]             data_byte;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [SAMPLE_W-1:0]    left_sample;
	logic signed [SAMPLE_W-1:0]    right_sample;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [CFG_INDEX_W-1:0]        cfg_index;
	logic [GAIN_W-1:0]             cfg_data;

	frame_scoreboard sb;
	int unsigned     in_idle_pct;
	int unsigned     out_idle_pct;
	int unsigned     stall_cycles;

	pcm_frame_gain_stereo_packer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Receiver: decide on the falling edge whether to take a beat next cycle.
	always @(negedge clk) begin
		out_ready = arst_n && ($urandom_range(99) >= out_idle_pct);
	end

	// Check every output beat taken at the rising edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_frame(left_sample, right_sample);
	end

	// Watchdog: any beat on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Send one stream byte, with a random gap before it; returns on a falling edge.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < in_idle_pct)
			@(negedge clk);
		in_valid  = 1'b1;
		data_byte = b;
		do
			@(posedge clk);
		while (!in_ready);
		sb.take_byte(b);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Write one register; called on a falling edge with the block idle.
	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Wait until every expected frame is out and the pipeline has settled.
	task automatic wait_idle();
		while (sb.expected_frames.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [GAIN_W-1:0] d;
		int unsigned       sent;
		int unsigned       len;
		int unsigned       pick;
		logic [BYTE_W-1:0] b;

		sb           = new();
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		data_byte    = '0;
		out_ready    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_GAIN_Q15;
		cfg_data     = '0;
		stall_cycles = 0;
		in_idle_pct  = 32;
		out_idle_pct = 55;

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Stereo at unity gain: most negative left, most positive right.
		send_byte(8'h00); send_byte(8'h80); send_byte(8'hFF); send_byte(8'h7F);

		// Half gain rounds toward minus infinity: -1 stays -1, +1 becomes 0.
		wait_idle();
		cfg_write(CFG_GAIN_Q15, 16'h4000);
		send_byte(8'hFF); send_byte(8'hFF); send_byte(8'h01); send_byte(8'h00);

		// Largest gain below unity on the extreme samples.
		wait_idle();
		cfg_write(CFG_GAIN_Q15, 16'h7FFF);
		send_byte(8'h00); send_byte(8'h80); send_byte(8'hFF); send_byte(8'h7F);

		// Gain above unity passes through; upper data bits and the unused index are ignored.
		wait_idle();
		cfg_write(CFG_GAIN_Q15, 16'hFFFF);
		cfg_write(CFG_MUTE_ENABLE, 16'hFFFE);
		cfg_write(CFG_UNUSED_INDEX, 16'hFFFF);
		send_byte(8'h34); send_byte(8'h12); send_byte(8'hCD); send_byte(8'hAB);

		// Switch to mono with three stereo bytes held: the next byte pairs with the first.
		send_byte(8'h11); send_byte(8'h22); send_byte(8'h33);
		wait_idle();
		cfg_write(CFG_STEREO_INPUT, 16'hFFFE);
		send_byte(8'h44);

		// Switch to stereo with one mono byte held: it opens the stereo frame.
		send_byte(8'h55);
		wait_idle();
		cfg_write(CFG_STEREO_INPUT, 16'h0001);
		send_byte(8'h66); send_byte(8'h77); send_byte(8'h88);

		// Mute forces zero, here in mono at zero gain.
		wait_idle();
		cfg_write(CFG_MUTE_ENABLE, 16'h0001);
		cfg_write(CFG_GAIN_Q15, 16'h0000);
		cfg_write(CFG_STEREO_INPUT, 16'h0000);
		send_byte(8'h01); send_byte(8'h02);

		// Random segments; settings change between segments, often mid-frame.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					in_idle_pct  = 32;
					out_idle_pct = 55;
				end
				1: begin
					in_idle_pct  = 55;
					out_idle_pct = 32;
				end
				default: begin
					in_idle_pct  = 0;
					out_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < BYTES_PER_PHASE) begin
				wait_idle();
				if ($urandom_range(1)) begin
					case ($urandom_range(5))
						0: d = 16'h0000;
						1: d = 16'h7FFF;
						2: d = UNITY_GAIN;
						3: d = 16'hFFFF;
						4: d = 16'($urandom_range(32767));
						default: d = 16'($urandom);
					endcase
					cfg_write(CFG_GAIN_Q15, d);
				end
				if ($urandom_range(1)) begin
					d    = 16'($urandom);
					d[0] = ($urandom_range(4) == 0);
					cfg_write(CFG_MUTE_ENABLE, d);
				end
				if ($urandom_range(1)) begin
					d = 16'($urandom);
					cfg_write(CFG_STEREO_INPUT, d);
				end
				if ($urandom_range(7) == 0) begin
					d = 16'($urandom);
					cfg_write(CFG_UNUSED_INDEX, d);
				end
				len = $urandom_range(20, 80);
				repeat (len) begin
					// Lean toward bytes that make extreme samples.
					pick = $urandom_range(7);
					case (pick)
						0: b = 8'h00;
						1: b = 8'hFF;
						2: b = 8'h80;
						3: b = 8'h7F;
						default: b = 8'($urandom);
					endcase
					send_byte(b);
				end
				sent += len;
			end
		end

		wait_idle();
		if (sb.mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/pfgsp_pkg.sv
hw/rtl/pfgsp_scale.sv
hw/rtl/pcm_frame_gain_stereo_packer.sv
hw/rtl/pfgsp_checker.sv
tb/pcm_frame_gain_stereo_packer_tb.sv
